// ----- rtl/hrhp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_pkg: shared types and constants of the response header parser
// Byte classes passed from the front end to the parse engine, the parse
// phases, the error codes and the keyword tables used for name and value
// matching.
// ----------------------------------------------------------------------------
package hrhp_pkg;

  // One classified header byte, as queued between front end and engine.
  typedef struct packed {
    logic       is_sp;     // space or tab
    logic       is_cr;
    logic       is_lf;
    logic       is_colon;
    logic       is_digit;
    logic [3:0] digit;
    logic [7:0] lc;        // byte folded to lower case
    logic       last;
  } item_t;

  typedef enum logic [7:0] {
    PH_LEAD  = 8'b0000_0001,
    PH_VERS  = 8'b0000_0010,
    PH_DEAD  = 8'b0000_0100,
    PH_STAT  = 8'b0000_1000,
    PH_REST  = 8'b0001_0000,
    PH_LINE  = 8'b0010_0000,
    PH_NAME  = 8'b0100_0000,
    PH_VALUE = 8'b1000_0000
  } phase_t;

  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_BLANK     = 2'd1;
  localparam logic [1:0] ERR_NO_LF     = 2'd2;
  localparam logic [1:0] ERR_NO_STATUS = 2'd3;

  localparam int unsigned KW_BITS = 256;

  localparam logic [KW_BITS-1:0] KW_TE = KW_BITS'("transfer-encoding");
  localparam logic [KW_BITS-1:0] KW_CL = KW_BITS'("content-length");
  localparam logic [KW_BITS-1:0] KW_CN = KW_BITS'("connection");
  localparam logic [KW_BITS-1:0] KW_PC = KW_BITS'("proxy-connection");
  localparam logic [KW_BITS-1:0] KW_CH = KW_BITS'("chunked");
  localparam logic [KW_BITS-1:0] KW_KA = KW_BITS'("keep-alive");

  localparam logic [4:0] LEN_TE = 5'd17;
  localparam logic [4:0] LEN_CL = 5'd14;
  localparam logic [4:0] LEN_CN = 5'd10;
  localparam logic [4:0] LEN_PC = 5'd16;
  localparam logic [4:0] LEN_CH = 5'd7;
  localparam logic [4:0] LEN_KA = 5'd10;

  localparam logic [3:0] NO_NAME = 4'hF;

  // The string literal is right-justified, so character p of a keyword of
  // length n sits in byte n-1-p counted from the least significant end.
  function automatic logic kw_hit(input logic [KW_BITS-1:0] kw, input logic [4:0] len,
                                  input logic [4:0] pos, input logic [7:0] lc);
    logic [4:0] idx;
    idx = len - 5'd1 - pos;
    return (pos < len) && (kw[{idx, 3'b000} +: 8] == lc);
  endfunction

  function automatic logic [4:0] hdr_len(input logic [1:0] k);
    logic [4:0] n;
    case (k)
      2'd0:    n = LEN_TE;
      2'd1:    n = LEN_CL;
      2'd2:    n = LEN_CN;
      default: n = LEN_PC;
    endcase
    return n;
  endfunction

  function automatic logic hdr_hit(input logic [1:0] k, input logic [4:0] pos,
                                   input logic [7:0] lc);
    logic h;
    case (k)
      2'd0:    h = kw_hit(KW_TE, LEN_TE, pos, lc);
      2'd1:    h = kw_hit(KW_CL, LEN_CL, pos, lc);
      2'd2:    h = kw_hit(KW_CN, LEN_CN, pos, lc);
      default: h = kw_hit(KW_PC, LEN_PC, pos, lc);
    endcase
    return h;
  endfunction

endpackage

// ----- rtl/http_response_header_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_response_header_parser: streaming HTTP/1.1 response header parser
// Reads a response header one byte per transfer and delivers one summary
// (status code, content length, chunked, keep-alive, header count) per
// header block, on the byte marked last.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake           | Payload
//  ---------+---------------------+-------------------------------------------
//  input    | push / full         | data_byte, last_byte
//  result   | empty / pop         | error_code, status_code, content_length,
//           |                     | chunked, keep_alive, header_count
//
// One byte is taken every cycle while full is low; the parse engine retires
// one byte per cycle from a two-entry queue behind the classifier while the
// result queue has room, so the summary for a last byte is written into the
// result queue as the engine takes it, behind any results not yet popped.
// Reset (rst, synchronous) empties both queues and returns the parser to the
// leading-whitespace phase. A result waiting in the result queue holds the
// engine only once that queue is full; full rises when the input queue is
// full, so both sides may stall independently.
//
// Structure: the front end classifies each byte (whitespace, line feed,
// colon, digit, lower-cased letter) and writes it into the input queue. The
// engine pops one classified byte per cycle when take is high and updates the
// running state: status line token tracking, per-character keyword matching
// against the recognised header names and values, and the saturating decimal
// accumulator for Content-Length. On the last byte the summary is pushed
// into the result queue and the running state is cleared for the next block.
module http_response_header_parser #(
  parameter int unsigned LENGTH_BITS = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output logic                   empty,
  input  logic                   pop,
  output logic [1:0]             error_code,
  output logic [9:0]             status_code,
  output logic [LENGTH_BITS-1:0] content_length,
  output logic                   chunked,
  output logic                   keep_alive,
  output logic [7:0]             header_count
);

  localparam int unsigned ITEM_W = $bits(hrhp_pkg::item_t);
  localparam int unsigned RES_W  = 2 + 10 + LENGTH_BITS + 1 + 1 + 8;

  hrhp_pkg::item_t        front_item;
  hrhp_pkg::item_t        back_item;
  logic                   in_empty;
  logic                   res_full;
  logic                   take;

  logic                   res_valid;
  logic [1:0]             res_error;
  logic [9:0]             res_http_code;
  logic [LENGTH_BITS-1:0] res_body_len;
  logic                   res_chunked;
  logic                   res_keep_alive;
  logic [7:0]             res_count;
  logic [RES_W-1:0]       res_word;
  logic [RES_W-1:0]       out_word;

  hrhp_front u_front (
    .data_byte (data_byte),
    .last_byte (last_byte),
    .item      (front_item)
  );

  hrhp_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (2)
  ) u_in_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (front_item),
    .full    (full),
    .rd_en   (take),
    .rd_data (back_item),
    .empty   (in_empty)
  );

  // The engine advances whenever a byte is queued and a result could be stored.
  assign take = !in_empty && !res_full;

  hrhp_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .item           (back_item),
    .take           (take),
    .res_valid      (res_valid),
    .res_error      (res_error),
    .res_http_code  (res_http_code),
    .res_body_len   (res_body_len),
    .res_chunked    (res_chunked),
    .res_keep_alive (res_keep_alive),
    .res_count      (res_count)
  );

  assign res_word = {res_error, res_http_code, res_body_len, res_chunked, res_keep_alive,
                     res_count};

  hrhp_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_valid),
    .wr_data (res_word),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_word),
    .empty   (empty)
  );

  assign {error_code, status_code, content_length, chunked, keep_alive, header_count} = out_word;

endmodule

// ----- rtl/hrhp_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_front: byte classifier
// Sorts each incoming header byte into the classes the parse engine needs
// and folds letters to lower case.
// ----------------------------------------------------------------------------
module hrhp_front (
  input  logic [7:0]     data_byte,
  input  logic           last_byte,
  output hrhp_pkg::item_t item
);

  always_comb begin
    item.is_sp    = (data_byte == 8'h20) || (data_byte == 8'h09);
    item.is_cr    = (data_byte == 8'h0D);
    item.is_lf    = (data_byte == 8'h0A);
    item.is_colon = (data_byte == 8'h3A);
    item.is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
    item.digit    = data_byte[3:0];
    item.lc       = ((data_byte >= 8'h41) && (data_byte <= 8'h5A)) ?
                    (data_byte | 8'h20) : data_byte;
    item.last     = last_byte;
  end

endmodule

// ----- rtl/hrhp_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_fifo: small synchronous queue
// Register-based first-in first-out queue; the head entry is visible while
// the queue is not empty.
// ----------------------------------------------------------------------------
module hrhp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/hrhp_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrhp_back: parse engine
// Consumes one classified byte per cycle when take is high, tracks the
// status line and header lines, and emits the summary on the last byte.
// ----------------------------------------------------------------------------
module hrhp_back #(
  parameter int unsigned LENGTH_BITS = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  hrhp_pkg::item_t        item,
  input  logic                   take,
  output logic                   res_valid,
  output logic [1:0]             res_error,
  output logic [9:0]             res_http_code,
  output logic [LENGTH_BITS-1:0] res_body_len,
  output logic                   res_chunked,
  output logic                   res_keep_alive,
  output logic [7:0]             res_count
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  hrhp_pkg::phase_t       phase, phase_next;
  logic [4:0]             name_pos, name_pos_next;
  logic [3:0]             kw_hits, kw_hits_next;
  logic                   gap, gap_next;
  logic [1:0]             val_hits, val_hits_next;
  logic                   val_present, val_present_next;
  logic                   digits_live, digits_live_next;
  logic [LENGTH_BITS-1:0] num_acc, num_acc_next;
  logic [9:0]             status, status_next;
  logic [LENGTH_BITS-1:0] length, length_next;
  logic                   chunked_f, chunked_f_next;
  logic                   keep_f, keep_f_next;
  logic [7:0]             hdr_total, hdr_total_next;

  logic                   is_sptr;
  logic                   do_name;
  logic                   do_value;
  logic                   err_zero;
  logic [LENGTH_BITS+3:0] acc_wide;
  logic [9:0]             status_wide;

  assign is_sptr = item.is_sp || item.is_cr;

  always_comb begin
    phase_next       = phase;
    name_pos_next    = name_pos;
    kw_hits_next     = kw_hits;
    gap_next         = gap;
    val_hits_next    = val_hits;
    val_present_next = val_present;
    digits_live_next = digits_live;
    num_acc_next     = num_acc;
    status_next      = status;
    length_next      = length;
    chunked_f_next   = chunked_f;
    keep_f_next      = keep_f;
    hdr_total_next   = hdr_total;
    do_name          = 1'b0;
    do_value         = 1'b0;
    acc_wide         = '0;
    status_wide      = ({3'b000, status[6:0]} * 10'd10) + {6'd0, item.digit};

    case (phase)
      hrhp_pkg::PH_LEAD: begin
        if (!(is_sptr || item.is_lf)) begin
          phase_next = hrhp_pkg::PH_VERS;
          gap_next   = 1'b0;
        end
      end
      hrhp_pkg::PH_VERS: begin
        if (item.is_lf) begin
          phase_next = hrhp_pkg::PH_DEAD;
        end else if (is_sptr) begin
          gap_next = 1'b1;
        end else if (gap) begin
          phase_next       = hrhp_pkg::PH_STAT;
          digits_live_next = item.is_digit;
          status_next      = item.is_digit ? {6'd0, item.digit} : 10'd0;
        end
      end
      hrhp_pkg::PH_DEAD: begin
      end
      hrhp_pkg::PH_STAT: begin
        if (item.is_lf) begin
          phase_next = hrhp_pkg::PH_LINE;
        end else if (is_sptr) begin
          phase_next = hrhp_pkg::PH_REST;
        end else if (digits_live && item.is_digit) begin
          status_next = (status > 10'd99) ? 10'd999 : status_wide;
        end else begin
          digits_live_next = 1'b0;
        end
      end
      hrhp_pkg::PH_REST: begin
        if (item.is_lf) begin
          phase_next = hrhp_pkg::PH_LINE;
        end
      end
      hrhp_pkg::PH_LINE: begin
        if (is_sptr || item.is_lf) begin
          phase_next = phase;
        end else if (item.is_colon) begin
          kw_hits_next     = hrhp_pkg::NO_NAME;
          val_present_next = 1'b0;
          phase_next       = hrhp_pkg::PH_VALUE;
        end else begin
          phase_next    = hrhp_pkg::PH_NAME;
          name_pos_next = 5'd0;
          kw_hits_next  = 4'hF;
          gap_next      = 1'b0;
          do_name       = 1'b1;
        end
      end
      hrhp_pkg::PH_NAME: begin
        if (item.is_lf) begin
          if (hdr_total != 8'hFF) hdr_total_next = hdr_total + 8'd1;
          phase_next = hrhp_pkg::PH_LINE;
        end else if (item.is_colon) begin
          // Keep only the keywords whose full length was matched.
          for (int i = 0; i < 4; i++) begin
            kw_hits_next[i] = kw_hits[i] && (name_pos == hrhp_pkg::hdr_len(2'(i)));
          end
          val_present_next = 1'b0;
          phase_next       = hrhp_pkg::PH_VALUE;
        end else begin
          do_name = 1'b1;
        end
      end
      hrhp_pkg::PH_VALUE: begin
        if (item.is_lf) begin
          if (kw_hits != hrhp_pkg::NO_NAME) begin
            if (hdr_total != 8'hFF) hdr_total_next = hdr_total + 8'd1;
            if (val_present) begin
              if (kw_hits[0]) begin
                chunked_f_next = val_hits[0] && (name_pos == hrhp_pkg::LEN_CH);
              end else if (kw_hits[1]) begin
                chunked_f_next = 1'b0;
                length_next    = num_acc;
              end else if (kw_hits[2] || kw_hits[3]) begin
                keep_f_next = val_hits[1] && (name_pos == hrhp_pkg::LEN_KA);
              end
            end
          end
          phase_next = hrhp_pkg::PH_LINE;
        end else if (val_present || !is_sptr) begin
          if (!val_present) begin
            val_present_next = 1'b1;
            gap_next         = 1'b0;
            name_pos_next    = 5'd0;
            val_hits_next    = 2'b11;
            digits_live_next = 1'b1;
            num_acc_next     = '0;
          end
          do_value = 1'b1;
        end
      end
      default: begin
        phase_next = hrhp_pkg::PH_LEAD;
      end
    endcase

    // A byte of a header name.
    if (do_name) begin
      if (item.is_sp) begin
        gap_next = 1'b1;
      end else begin
        if (gap_next) kw_hits_next = 4'h0;
        for (int i = 0; i < 4; i++) begin
          if (!hrhp_pkg::hdr_hit(2'(i), name_pos_next, item.lc)) kw_hits_next[i] = 1'b0;
        end
        if (name_pos_next != 5'd31) name_pos_next = name_pos_next + 5'd1;
      end
    end

    // A byte of a header value: keyword match and decimal accumulation.
    if (do_value) begin
      if (is_sptr) begin
        gap_next         = 1'b1;
        digits_live_next = 1'b0;
      end else begin
        if (gap_next) val_hits_next = 2'b00;
        acc_wide = ({4'd0, num_acc_next} << 3) + ({4'd0, num_acc_next} << 1)
                 + (LENGTH_BITS + 4)'(item.digit);
        if (digits_live_next && item.is_digit) begin
          num_acc_next = (acc_wide > {4'd0, LEN_MAX}) ? LEN_MAX : acc_wide[LENGTH_BITS-1:0];
        end else begin
          digits_live_next = 1'b0;
        end
        if (!hrhp_pkg::kw_hit(hrhp_pkg::KW_CH, hrhp_pkg::LEN_CH, name_pos_next, item.lc)) begin
          val_hits_next[0] = 1'b0;
        end
        if (!hrhp_pkg::kw_hit(hrhp_pkg::KW_KA, hrhp_pkg::LEN_KA, name_pos_next, item.lc)) begin
          val_hits_next[1] = 1'b0;
        end
        if (name_pos_next != 5'd31) name_pos_next = name_pos_next + 5'd1;
      end
    end
  end

  // Summary of the block, taken from the state after the last byte.
  always_comb begin
    res_valid = take && item.last;
    case (phase_next)
      hrhp_pkg::PH_LEAD:                                       res_error = hrhp_pkg::ERR_BLANK;
      hrhp_pkg::PH_DEAD:                                       res_error = hrhp_pkg::ERR_NO_STATUS;
      hrhp_pkg::PH_LINE, hrhp_pkg::PH_NAME, hrhp_pkg::PH_VALUE: res_error = hrhp_pkg::ERR_OK;
      default:                                                 res_error = hrhp_pkg::ERR_NO_LF;
    endcase
    err_zero       = (res_error == hrhp_pkg::ERR_OK);
    res_http_code  = err_zero ? status_next : 10'd0;
    res_body_len   = err_zero ? length_next : '0;
    res_chunked    = err_zero && chunked_f_next;
    res_keep_alive = err_zero && keep_f_next;
    res_count      = err_zero ? hdr_total_next : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && item.last)) begin
      phase       <= hrhp_pkg::PH_LEAD;
      name_pos    <= 5'd0;
      kw_hits     <= 4'hF;
      gap         <= 1'b0;
      val_hits    <= 2'b11;
      val_present <= 1'b0;
      digits_live <= 1'b0;
      num_acc     <= '0;
      status      <= 10'd0;
      length      <= '0;
      chunked_f   <= 1'b0;
      keep_f      <= 1'b0;
      hdr_total   <= 8'd0;
    end else if (take) begin
      phase       <= phase_next;
      name_pos    <= name_pos_next;
      kw_hits     <= kw_hits_next;
      gap         <= gap_next;
      val_hits    <= val_hits_next;
      val_present <= val_present_next;
      digits_live <= digits_live_next;
      num_acc     <= num_acc_next;
      status      <= status_next;
      length      <= length_next;
      chunked_f   <= chunked_f_next;
      keep_f      <= keep_f_next;
      hdr_total   <= hdr_total_next;
    end
  end

endmodule

// ----- tb/sv/tb_http_response_header_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_http_response_header_parser: self-checking bench for the header parser
// Streams response header blocks into the parser one byte per transfer and
// predicts each block summary in a behavioural parser of its own. A short
// table of hand-picked bytes comes first, followed by generated header blocks
// (mostly well-formed, some broken, some pure noise) under random idling on
// both channels, including a long result stall and a full drain pause.
// ----------------------------------------------------------------------------
module tb_http_response_header_parser;

  // Timing and run shape.
  localparam int CLK_HALF_NS  = 2;
  localparam int TIMEOUT_NS   = 10_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int ITEM_TARGET  = 600;

  // Characters with a meaning to the parser.
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [47:0] LEN_MAX = 48'hFFFF_FFFF_FFFF;

  // One block summary as it appears on the result ports.
  typedef struct packed {
    logic [1:0]  err;
    logic [9:0]  status;
    logic [47:0] clen;
    logic        chunk;
    logic        keep;
    logic [7:0]  lines;
  } summary_t;

  // One row of the directed script: a byte, its last mark and, where the
  // outcome is obvious by eye, the summary typed in by hand.
  typedef struct packed {
    logic [7:0] b;
    logic       l;
    logic       typed;
    summary_t   want;
  } row_t;

  localparam summary_t NONE = '0;

  localparam row_t SCRIPT [25] = '{
    // Nothing but whitespace before the last byte.
    '{CH_SP,   1'b1, 1'b1, '{hrhp_pkg::ERR_BLANK, 10'd0, 48'd0, 1'b0, 1'b0, 8'd0}},
    // The status line ends before any status token.
    '{"H",     1'b0, 1'b0, NONE},
    '{CH_LF,   1'b1, 1'b1, '{hrhp_pkg::ERR_NO_STATUS, 10'd0, 48'd0, 1'b0, 1'b0, 8'd0}},
    // Top byte value as the version, a tab gap, then no newline at all.
    '{8'hFF,   1'b0, 1'b0, NONE},
    '{CH_TAB,  1'b0, 1'b0, NONE},
    '{"9",     1'b0, 1'b0, NONE},
    '{8'h00,   1'b1, 1'b1, '{hrhp_pkg::ERR_NO_LF, 10'd0, 48'd0, 1'b0, 1'b0, 8'd0}},
    // A good status line, a line that starts with a colon (not counted),
    // a line with no colon (counted) and a final line with no newline.
    '{CH_CR,   1'b0, 1'b0, NONE},
    '{"H",     1'b0, 1'b0, NONE},
    '{CH_SP,   1'b0, 1'b0, NONE},
    '{"2",     1'b0, 1'b0, NONE},
    '{"0",     1'b0, 1'b0, NONE},
    '{"4",     1'b0, 1'b0, NONE},
    '{CH_LF,   1'b0, 1'b0, NONE},
    '{":",     1'b0, 1'b0, NONE},
    '{"x",     1'b0, 1'b0, NONE},
    '{CH_LF,   1'b0, 1'b0, NONE},
    '{"A",     1'b0, 1'b0, NONE},
    '{CH_LF,   1'b0, 1'b0, NONE},
    '{"B",     1'b0, 1'b0, NONE},
    '{"!",     1'b1, 1'b1, '{hrhp_pkg::ERR_OK, 10'd204, 48'd0, 1'b0, 1'b0, 8'd1}},
    // A status token that does not begin with a digit.
    '{"h",     1'b0, 1'b0, NONE},
    '{CH_SP,   1'b0, 1'b0, NONE},
    '{8'h80,   1'b0, 1'b0, NONE},
    '{CH_LF,   1'b1, 1'b0, NONE}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  error_code;
  logic [9:0]  status_code;
  logic [47:0] content_length;
  logic        chunked;
  logic        keep_alive;
  logic [7:0]  header_count;

  http_response_header_parser i_dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .empty          (empty),
    .pop            (pop),
    .error_code     (error_code),
    .status_code    (status_code),
    .content_length (content_length),
    .chunked        (chunked),
    .keep_alive     (keep_alive),
    .header_count   (header_count)
  );

  initial begin
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  // Header names and values that the parser recognises, in lower case.
  string hdr_word [4] = '{"transfer-encoding", "content-length", "connection",
                          "proxy-connection"};
  string val_word [2] = '{"chunked", "keep-alive"};
  string near_val [4] = '{"keep alive", "chunke", "chunkeds", "Keep-Alive2"};
  string token_chars = "abcdefghijklmnopqrstuvwxyzXYZ-_.0123456789";

  // Summaries still owed by the parser, oldest first.
  summary_t summary_q [$];

  // Bookkeeping for the checks and the closing report.
  int errors       = 0;
  int checked      = 0;
  int blocks_sent  = 0;
  int sent_bytes   = 0;
  int held_cycles  = 0;
  bit gapless      = 1'b0;
  bit hold_results = 1'b0;

  // --------------------------------------------------------------------------
  // Behavioural parser. It mirrors the byte-serial parse: leading whitespace,
  // version token, status token, then header lines split into name and value
  // with per-character keyword matching.
  // --------------------------------------------------------------------------
  hrhp_pkg::phase_t ph;
  logic [4:0]  pos;         // character position within the name or value
  logic [3:0]  name_hits;   // header keywords still matching the name
  logic        gap;         // whitespace seen inside the current token
  logic [1:0]  val_hits;    // value keywords still matching the value
  logic        val_seen;    // the value has a non-blank character
  logic        digits_ok;   // the number so far is made of digits only
  logic [47:0] num;
  logic [9:0]  status;
  logic [47:0] clen;
  logic        chunk_f;
  logic        keep_f;
  logic [7:0]  lines;

  function automatic void clear_parser();
    ph        = hrhp_pkg::PH_LEAD;
    pos       = '0;
    name_hits = 4'hF;
    gap       = 1'b0;
    val_hits  = 2'b11;
    val_seen  = 1'b0;
    digits_ok = 1'b0;
    num       = '0;
    status    = '0;
    clen      = '0;
    chunk_f   = 1'b0;
    keep_f    = 1'b0;
    lines     = '0;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SP || c == CH_TAB;
  endfunction

  function automatic logic is_pad(logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_CR;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] fold(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic void step_pos();
    if (pos < 5'd31) pos = pos + 5'd1;
  endfunction

  function automatic void count_line();
    if (lines != 8'hFF) lines = lines + 8'd1;
  endfunction

  function automatic void name_char(logic [7:0] c);
    logic [7:0] lc;
    lc = fold(c);
    if (is_blank(c)) begin
      gap = 1'b1;
      return;
    end
    // Anything after an inner gap rules out every keyword.
    if (gap) name_hits = '0;
    for (int i = 0; i < 4; i++) begin
      if (!(pos < hdr_word[i].len() && lc == hdr_word[i][pos])) name_hits[i] = 1'b0;
    end
    step_pos();
  endfunction

  function automatic void value_char(logic [7:0] c);
    logic [7:0]  lc;
    logic [47:0] d;
    lc = fold(c);
    if (is_pad(c)) begin
      gap = 1'b1;
      digits_ok = 1'b0;
      return;
    end
    if (gap) val_hits = '0;
    if (digits_ok && is_digit(c)) begin
      d = 48'(c - 8'h30);
      num = (num > (LEN_MAX - d) / 48'd10) ? LEN_MAX : num * 48'd10 + d;
    end else begin
      digits_ok = 1'b0;
    end
    for (int i = 0; i < 2; i++) begin
      if (!(pos < val_word[i].len() && lc == val_word[i][pos])) val_hits[i] = 1'b0;
    end
    step_pos();
  endfunction

  function automatic void open_value();
    val_seen = 1'b0;
    ph = hrhp_pkg::PH_VALUE;
  endfunction

  // The line feed that ends a value applies the header, if it is one we know.
  function automatic void close_value();
    logic ch, ka;
    if (name_hits != hrhp_pkg::NO_NAME) begin
      count_line();
      if (val_seen) begin
        ch = val_hits[0] && pos == val_word[0].len();
        ka = val_hits[1] && pos == val_word[1].len();
        if (name_hits[0]) begin
          chunk_f = ch;
        end else if (name_hits[1]) begin
          chunk_f = 1'b0;
          clen = num;
        end else if (name_hits[3:2] != 2'b00) begin
          keep_f = ka;
        end
      end
    end
    ph = hrhp_pkg::PH_LINE;
  endfunction

  function automatic void parse_byte(logic [7:0] c);
    logic [3:0] exact;
    case (ph)
      hrhp_pkg::PH_LEAD: begin
        if (!(is_pad(c) || c == CH_LF)) begin
          ph = hrhp_pkg::PH_VERS;
          gap = 1'b0;
        end
      end
      hrhp_pkg::PH_VERS: begin
        if (c == CH_LF) begin
          ph = hrhp_pkg::PH_DEAD;
        end else if (is_pad(c)) begin
          gap = 1'b1;
        end else if (gap) begin
          ph = hrhp_pkg::PH_STAT;
          digits_ok = is_digit(c);
          status = is_digit(c) ? 10'(c - 8'h30) : 10'd0;
        end
      end
      hrhp_pkg::PH_STAT: begin
        if (c == CH_LF) begin
          ph = hrhp_pkg::PH_LINE;
        end else if (is_pad(c)) begin
          ph = hrhp_pkg::PH_REST;
        end else if (digits_ok && is_digit(c)) begin
          status = (status > 10'd99) ? 10'd999 : status * 10'd10 + 10'(c - 8'h30);
        end else begin
          digits_ok = 1'b0;
        end
      end
      hrhp_pkg::PH_REST: begin
        if (c == CH_LF) ph = hrhp_pkg::PH_LINE;
      end
      hrhp_pkg::PH_LINE: begin
        if (c == CH_COLON) begin
          name_hits = hrhp_pkg::NO_NAME;
          open_value();
        end else if (!(is_pad(c) || c == CH_LF)) begin
          ph = hrhp_pkg::PH_NAME;
          pos = '0;
          name_hits = 4'hF;
          gap = 1'b0;
          name_char(c);
        end
      end
      hrhp_pkg::PH_NAME: begin
        if (c == CH_LF) begin
          count_line();
          ph = hrhp_pkg::PH_LINE;
        end else if (c == CH_COLON) begin
          // Only a full-length match survives the colon.
          exact = '0;
          for (int i = 0; i < 4; i++) begin
            if (name_hits[i] && pos == hdr_word[i].len()) exact[i] = 1'b1;
          end
          name_hits = exact;
          open_value();
        end else begin
          name_char(c);
        end
      end
      hrhp_pkg::PH_VALUE: begin
        if (c == CH_LF) begin
          close_value();
        end else if (val_seen || !is_pad(c)) begin
          if (!val_seen) begin
            val_seen = 1'b1;
            gap = 1'b0;
            pos = '0;
            val_hits = 2'b11;
            digits_ok = 1'b1;
            num = '0;
          end
          value_char(c);
        end
      end
      default: ;
    endcase
  endfunction

  // Summary owed for the byte marked last; the parser then starts afresh.
  function automatic summary_t take_summary();
    summary_t s;
    s = '0;
    case (ph)
      hrhp_pkg::PH_LEAD: s.err = hrhp_pkg::ERR_BLANK;
      hrhp_pkg::PH_DEAD: s.err = hrhp_pkg::ERR_NO_STATUS;
      hrhp_pkg::PH_LINE, hrhp_pkg::PH_NAME, hrhp_pkg::PH_VALUE: s.err = hrhp_pkg::ERR_OK;
      default:           s.err = hrhp_pkg::ERR_NO_LF;
    endcase
    if (s.err == hrhp_pkg::ERR_OK) begin
      s.status = status;
      s.clen   = clen;
      s.chunk  = chunk_f;
      s.keep   = keep_f;
      s.lines  = lines;
    end
    clear_parser();
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Header text generation. Each block is built as a byte queue and then
  // sent with the last mark on its final byte.
  // --------------------------------------------------------------------------
  logic [7:0] blk [$];

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) blk.push_back(s[i]);
  endfunction

  // Letters come out in random case, since names and values are matched
  // without regard to case.
  function automatic void put_word(string s);
    logic [7:0] ch;
    for (int i = 0; i < s.len(); i++) begin
      ch = s[i];
      if (ch >= "a" && ch <= "z" && $urandom_range(0, 1)) ch = ch - 8'd32;
      blk.push_back(ch);
    end
  endfunction

  function automatic void put_pad(int lo, int hi);
    repeat ($urandom_range(lo, hi)) blk.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
  endfunction

  function automatic void put_digits(int n);
    repeat (n) blk.push_back(8'(8'h30 + $urandom_range(0, 9)));
  endfunction

  function automatic void put_token(int n);
    repeat (n) blk.push_back(token_chars[$urandom_range(0, token_chars.len() - 1)]);
  endfunction

  function automatic void put_noise(int n);
    repeat (n) blk.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_status_line();
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0:       blk.push_back(CH_SP);
        1:       blk.push_back(CH_TAB);
        2:       blk.push_back(CH_CR);
        default: blk.push_back(CH_LF);
      endcase
    end
    if ($urandom_range(0, 1)) put_text("HTTP/1.1");
    else put_token($urandom_range(1, 4));
    put_pad(1, 2);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5, 6: begin
        blk.push_back(8'(8'h30 + $urandom_range(1, 5)));
        put_digits(2);
      end
      7: put_digits($urandom_range(4, 5));      // runs into saturation
      8: begin
        put_text("+");                          // a sign is not a digit
        put_digits(3);
      end
      default: begin
        put_digits(1);
        put_token(1);
        put_digits(1);
      end
    endcase
    if ($urandom_range(0, 1)) begin
      put_text(" ");
      put_token($urandom_range(1, 6));
    end
    if ($urandom_range(0, 3) != 0) blk.push_back(CH_CR);
    blk.push_back(CH_LF);
  endfunction

  function automatic void put_value(int vkind);
    case (vkind)
      0: put_word(val_word[0]);
      1: put_word(val_word[1]);
      2: put_digits($urandom_range(1, 6));
      3: put_digits($urandom_range(13, 20));
      4: put_text($urandom_range(0, 1) ? "281474976710655" : "281474976710656");
      5: begin
        case ($urandom_range(0, 2))
          0: begin
            put_digits(2);
            put_token(2);
          end
          1: begin
            put_text("+");
            put_digits(3);
          end
          default: put_text("-1");
        endcase
      end
      6: ;                                      // empty value
      7: put_token($urandom_range(1, 8));
      8: put_text(near_val[$urandom_range(0, 3)]);
      default: put_word("close");
    endcase
  endfunction

  function automatic void put_header_line();
    int    kind, k, p, vkind;
    string w;
    kind = $urandom_range(0, 10);
    k = $urandom_range(0, 3);
    w = hdr_word[k];
    put_pad(0, 1);
    case (kind)
      0, 1, 2, 3, 4, 5: put_word(w);
      6: begin
        // One character short, or one too many.
        if ($urandom_range(0, 1)) begin
          put_word(w.substr(0, w.len() - 2));
        end else begin
          put_word(w);
          put_token(1);
        end
      end
      7: put_token($urandom_range(1, 8));
      8: put_token($urandom_range(30, 40));
      9: begin
        // A blank inside the name spoils the match.
        p = $urandom_range(1, w.len() - 1);
        put_word(w.substr(0, p - 1));
        blk.push_back(CH_SP);
        put_word(w.substr(p, w.len() - 1));
      end
      default: ;                                // colon at the start of the line
    endcase
    put_pad(0, 1);
    if (kind != 10 && $urandom_range(0, 9) == 0) begin
      blk.push_back(CH_LF);
      return;
    end
    blk.push_back(CH_COLON);
    put_pad(0, 2);
    // Known names mostly get a value that suits them.
    if (kind <= 5 && $urandom_range(0, 3) != 0) begin
      case (k)
        0:       vkind = ($urandom_range(0, 4) != 0) ? 0 : 8;
        1:       vkind = $urandom_range(2, 5);
        default: vkind = ($urandom_range(0, 4) != 0) ? 1 : 9;
      endcase
    end else begin
      vkind = $urandom_range(0, 9);
    end
    put_value(vkind);
    put_pad(0, 2);
    if ($urandom_range(0, 1)) blk.push_back(CH_CR);
    blk.push_back(CH_LF);
  endfunction

  function automatic void build_block();
    int r;
    blk.delete();
    r = $urandom_range(0, 99);
    if (r < 12) begin
      put_noise($urandom_range(1, 12));
    end else if (r < 20) begin
      if ($urandom_range(0, 1)) begin
        // Version only; everything after it is ignored.
        put_text("HTTP/1.1");
        put_pad(0, 1);
        blk.push_back(CH_CR);
        blk.push_back(CH_LF);
        if ($urandom_range(0, 1)) put_header_line();
      end else begin
        // Status line cut short before its line feed.
        put_status_line();
        void'(blk.pop_back());
      end
    end else begin
      put_status_line();
      repeat ($urandom_range(0, 5)) put_header_line();
      r = $urandom_range(0, 99);
      if (r < 70) begin
        blk.push_back(CH_CR);
        blk.push_back(CH_LF);
      end else if (r < 85) begin
        put_token($urandom_range(1, 6));        // final line with no newline
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input side. A byte is offered after a random gap and is transferred at
  // the first rising edge at which full is low; the expected summary is
  // queued once the last byte of a block has gone in.
  // --------------------------------------------------------------------------
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                           input summary_t want);
    int       idle;
    summary_t predicted;
    idle = gapless ? 0 : sender_gap();
    if (idle > 0) begin
      push <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    push      <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    do @(posedge clk); while (full);
    sent_bytes++;
    parse_byte(b);
    if (l) begin
      predicted = take_summary();
      summary_q.push_back(typed ? want : predicted);
      blocks_sent++;
    end
  endtask

  task automatic send_block();
    for (int i = 0; i < blk.size(); i++) send_byte(blk[i], i == blk.size() - 1, 1'b0, NONE);
  endtask

  // Waits until the parser owes nothing; it waits on the clock before the first check,
  // so push is never lowered and raised again in one time step.
  task automatic settle();
    push <= 1'b0;
    do @(posedge clk); while (summary_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Result side. Every transfer is checked against the oldest expectation.
  // --------------------------------------------------------------------------
  function automatic int receiver_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  function automatic void check_summary();
    summary_t want;
    if (summary_q.size() == 0) begin
      $display("%0t ns: unexpected result, error %0d status %0d length %0d chunked %0d",
               $time, error_code, status_code, content_length, chunked);
      errors++;
      return;
    end
    want = summary_q.pop_front();
    checked++;
    check_field("error_code", want.err, error_code);
    check_field("status_code", want.status, status_code);
    check_field("content_length", want.clen, content_length);
    check_field("chunked", want.chunk, chunked);
    check_field("keep_alive", want.keep, keep_alive);
    check_field("header_count", want.lines, header_count);
  endfunction

  initial begin
    int idle;
    do @(posedge clk); while (rst);
    forever begin
      // A long stall requested by the sender lets the result queue fill
      // up until the parser holds off its input.
      if (hold_results) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end
      idle = receiver_gap();
      if (idle > 0) begin
        pop <= 1'b0;
        repeat (idle) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      check_summary();
    end
  end

  // Cycles in which a byte was offered but the parser refused it.
  always @(posedge clk) begin
    if (!rst && push && full) held_cycles++;
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence.
  // --------------------------------------------------------------------------
  initial begin
    clear_parser();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Hand-picked bytes first.
    for (int r = 0; r < $size(SCRIPT); r++) begin
      send_byte(SCRIPT[r].b, SCRIPT[r].l, SCRIPT[r].typed, SCRIPT[r].want);
    end

    // Sender waits for every summary before the back-pressure burst.
    settle();

    // Tiny blocks back to back while the result side is held off.
    gapless = 1'b1;
    hold_results = 1'b1;
    repeat (24) begin
      blk.delete();
      put_noise($urandom_range(1, 3));
      send_block();
    end
    gapless = 1'b0;

    // Generated blocks; one in five goes in without any idle cycles.
    while (sent_bytes < ITEM_TARGET) begin
      gapless = ($urandom_range(0, 4) == 0);
      build_block();
      send_block();
    end
    gapless = 1'b0;

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d header blocks (%0d bytes), checked %0d summaries.",
             blocks_sent, sent_bytes, checked);
    $display("Input was held off by a full parser for %0d cycles.", held_cycles);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d summaries still owed.", summary_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/hrhp_pkg.sv
rtl/hrhp_front.sv
rtl/hrhp_fifo.sv
rtl/hrhp_back.sv
rtl/http_response_header_parser.sv
tb/sv/tb_http_response_header_parser.sv
